@@ rtl/windowed_moving_average_3axis_assert.svh @@
// Assertion macros for the windowed three-axis moving average.
// Expects i_clk and i_rst_n in the scope that uses them.
`ifndef WINDOWED_MOVING_AVERAGE_3AXIS_ASSERT_SVH
`define WINDOWED_MOVING_AVERAGE_3AXIS_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define WMA3_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define WMA3_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/wma3_pkg.sv @@
// Shared widths, constants and the ring entry type of the moving average block.
// No dependencies.
`timescale 1ns / 1ps

package wma3_pkg;

    localparam int RING_WINDOWS = 8;
    localparam int RING_AW      = $clog2(RING_WINDOWS);
    localparam int FILL_W       = $clog2(RING_WINDOWS + 1);

    localparam int SMP_W     = 16;
    localparam int AVG_W     = 16;
    localparam int SUM_W     = 32;
    localparam int CNT_W     = 16;
    localparam int TICK_W    = 26;
    localparam int OUT_CNT_W = 19;

    // Totals over the whole ring
    localparam int TOT_W  = SUM_W + RING_AW;
    localparam int TOTC_W = CNT_W + RING_AW;

    localparam logic [CNT_W-1:0]  COUNT_MAX        = '1;
    localparam logic [TICK_W-1:0] TICK_MAX         = '1;
    localparam logic [TICK_W-1:0] WINDOW_TICKS_RST = TICK_W'(1000000);

    typedef struct packed {
        logic signed [SUM_W-1:0] sum_x;
        logic signed [SUM_W-1:0] sum_y;
        logic signed [SUM_W-1:0] sum_z;
        logic        [CNT_W-1:0] count;
    } t_ring_entry;

    localparam int ENTRY_W = $bits(t_ring_entry);

endpackage

@@ rtl/wma3_ring_ram.sv @@
// Simple dual-port ring memory: one write port, one registered read port.
// Generic; no package dependencies.
`timescale 1ns / 1ps

module wma3_ring_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 112
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/wma3_div.sv @@
// Serial signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
// Depends on wma3_pkg for the total and average widths.
`timescale 1ns / 1ps

module wma3_div
    import wma3_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [TOT_W-1:0] i_dividend,
    input  logic [TOTC_W-1:0]       i_divisor,
    output logic                    o_done,
    output logic signed [AVG_W-1:0] o_quot
);

    localparam int STEP_W = $clog2(TOT_W + 1);

    logic [TOTC_W-1:0] r_rem;
    logic [TOT_W-1:0]  r_quo;
    logic [TOTC_W-1:0] r_div;
    logic              r_neg;
    logic              r_zero;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [TOTC_W:0]   w_rem_sh;
    logic              w_ge;
    logic [TOTC_W:0]   w_rem_nx;
    logic [TOT_W-1:0]  w_mag;
    logic [AVG_W-1:0]  w_q;

    assign w_mag    = i_dividend[TOT_W-1] ? TOT_W'(-i_dividend) : TOT_W'(i_dividend);
    assign w_rem_sh = {r_rem, r_quo[TOT_W-1]};
    assign w_ge     = w_rem_sh >= {1'b0, r_div};
    assign w_rem_nx = w_ge ? (w_rem_sh - {1'b0, r_div}) : w_rem_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= STEP_W'(TOT_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == STEP_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quo  <= w_mag;
            r_div  <= i_divisor;
            r_neg  <= i_dividend[TOT_W-1];
            r_zero <= (i_divisor == '0);
        end else if (r_busy) begin
            // remainder stays below a nonzero divisor, so the top bit is then clear
            r_rem <= w_rem_nx[TOTC_W-1:0];
            r_quo <= {r_quo[TOT_W-2:0], w_ge};
        end
    end

    assign w_q    = r_quo[AVG_W-1:0];
    assign o_done = r_done;
    assign o_quot = r_zero ? '0 : (r_neg ? AVG_W'(-w_q) : AVG_W'(w_q));

endmodule

@@ rtl/windowed_moving_average_3axis.sv @@
// Top level of the windowed three-axis moving average.
// Depends on wma3_pkg, wma3_ring_ram, wma3_div and the assertion macro header.
`timescale 1ns / 1ps
`include "windowed_moving_average_3axis_assert.svh"

// Usage
//   Input channel (i_valid / o_ready): i_mode = 1 is a one-microsecond tick,
//   i_mode = 0 carries a sample on i_sample_x/y/z. A sample that arrives once
//   the tick count exceeds the window length closes the open window.
//   Output channel (o_valid / i_ready): one item per close once the ring of
//   RING_WINDOWS closed windows is full: the truncated per-axis mean over the
//   ring (not counting the closing window) and the sample count behind it.
//   Ticks, samples that do not close a window and closes into a ring that is
//   not yet full are taken in S_IDLE, so o_ready stays high.
//   A close into a full ring reads the oldest window from the ring memory,
//   retires it in S_RETIRE, adds the closing window in S_ADD and runs three
//   serial dividers of TOT_W steps (one quotient bit per cycle); the result
//   is registered in S_DIV once the dividers are done and the output
//   register is free, and o_ready drops until then.
//   The output register holds its item while i_ready is low; a new input is
//   taken meanwhile, and a later result waits for the register to empty.
//   Reset (i_rst_n low, synchronous) empties the open window, ring and totals
//   and sets the window length to 1000000 ticks. i_cfg_we writes it at once.
module windowed_moving_average_3axis
    import wma3_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [TICK_W-1:0]           i_cfg_wdata,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_mode,
    input  logic signed [SMP_W-1:0]     i_sample_x,
    input  logic signed [SMP_W-1:0]     i_sample_y,
    input  logic signed [SMP_W-1:0]     i_sample_z,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [AVG_W-1:0]     o_avg_x,
    output logic signed [AVG_W-1:0]     o_avg_y,
    output logic signed [AVG_W-1:0]     o_avg_z,
    output logic [OUT_CNT_W-1:0]        o_total_samples
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RETIRE,
        S_ADD,
        S_DIV
    } t_state;

    t_state                  r_state,   n_state;
    logic [TICK_W-1:0]       r_window_ticks;
    logic signed [SUM_W-1:0] r_open_x,  n_open_x;
    logic signed [SUM_W-1:0] r_open_y,  n_open_y;
    logic signed [SUM_W-1:0] r_open_z,  n_open_z;
    logic [CNT_W-1:0]        r_open_cnt, n_open_cnt;
    logic [TICK_W-1:0]       r_elapsed, n_elapsed;
    logic [FILL_W-1:0]       r_fill,    n_fill;
    logic [RING_AW-1:0]      r_oldest,  n_oldest;
    logic signed [TOT_W-1:0] r_tot_x,   n_tot_x;
    logic signed [TOT_W-1:0] r_tot_y,   n_tot_y;
    logic signed [TOT_W-1:0] r_tot_z,   n_tot_z;
    logic [TOTC_W-1:0]       r_tot_cnt, n_tot_cnt;
    t_ring_entry             r_close,   n_close;
    logic [TOTC_W-1:0]       r_emit_cnt, n_emit_cnt;
    logic                    r_out_valid, n_out_valid;
    logic signed [AVG_W-1:0] r_avg_x,   n_avg_x;
    logic signed [AVG_W-1:0] r_avg_y,   n_avg_y;
    logic signed [AVG_W-1:0] r_avg_z,   n_avg_z;
    logic [OUT_CNT_W-1:0]    r_out_cnt, n_out_cnt;

    logic                    w_take;
    logic                    w_sample;
    logic                    w_tick;
    logic                    w_close;
    logic                    w_full;
    t_ring_entry             w_acc;
    logic [FILL_W:0]         w_slot_sum;
    logic [RING_AW-1:0]      w_append_slot;
    logic [RING_AW-1:0]      w_oldest_inc;

    logic                    w_ram_we;
    logic [RING_AW-1:0]      w_ram_waddr;
    t_ring_entry             w_ram_wdata;
    logic                    w_ram_re;
    logic [ENTRY_W-1:0]      w_ram_rdata;
    t_ring_entry             w_old;

    logic                    w_div_start;
    logic                    w_done_x, w_done_y, w_done_z;
    logic signed [AVG_W-1:0] w_quot_x, w_quot_y, w_quot_z;

    assign o_ready  = (r_state == S_IDLE);
    assign w_take   = i_valid & o_ready;
    assign w_sample = w_take & ~i_mode;
    assign w_tick   = w_take & i_mode;
    assign w_close  = w_sample && (r_elapsed > r_window_ticks);
    assign w_full   = (r_fill == FILL_W'(RING_WINDOWS));
    assign w_old    = t_ring_entry'(w_ram_rdata);

    // Open window with the current sample folded in; hold once the count saturates
    always_comb begin
        w_acc.sum_x = r_open_x;
        w_acc.sum_y = r_open_y;
        w_acc.sum_z = r_open_z;
        w_acc.count = r_open_cnt;
        if (r_open_cnt != COUNT_MAX) begin
            w_acc.sum_x = r_open_x + SUM_W'(i_sample_x);
            w_acc.sum_y = r_open_y + SUM_W'(i_sample_y);
            w_acc.sum_z = r_open_z + SUM_W'(i_sample_z);
            w_acc.count = r_open_cnt + 1'b1;
        end
    end

    // Ring slot arithmetic; the sum stays below twice the depth
    assign w_slot_sum    = (FILL_W + 1)'(r_oldest) + (FILL_W + 1)'(r_fill);
    assign w_append_slot = (w_slot_sum >= (FILL_W + 1)'(RING_WINDOWS))
                         ? RING_AW'(w_slot_sum - (FILL_W + 1)'(RING_WINDOWS))
                         : RING_AW'(w_slot_sum);
    assign w_oldest_inc  = (r_oldest == RING_AW'(RING_WINDOWS - 1))
                         ? '0 : r_oldest + 1'b1;

    always_comb begin
        n_state     = r_state;
        n_open_x    = r_open_x;
        n_open_y    = r_open_y;
        n_open_z    = r_open_z;
        n_open_cnt  = r_open_cnt;
        n_elapsed   = r_elapsed;
        n_fill      = r_fill;
        n_oldest    = r_oldest;
        n_tot_x     = r_tot_x;
        n_tot_y     = r_tot_y;
        n_tot_z     = r_tot_z;
        n_tot_cnt   = r_tot_cnt;
        n_close     = r_close;
        n_emit_cnt  = r_emit_cnt;
        n_out_valid = r_out_valid;
        n_avg_x     = r_avg_x;
        n_avg_y     = r_avg_y;
        n_avg_z     = r_avg_z;
        n_out_cnt   = r_out_cnt;
        w_ram_we    = 1'b0;
        w_ram_waddr = r_oldest;
        w_ram_wdata = r_close;
        w_ram_re    = 1'b0;
        w_div_start = 1'b0;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_tick && (r_elapsed != TICK_MAX)) begin
                    n_elapsed = r_elapsed + 1'b1;
                end
                if (w_sample) begin
                    if (!w_close) begin
                        n_open_x   = w_acc.sum_x;
                        n_open_y   = w_acc.sum_y;
                        n_open_z   = w_acc.sum_z;
                        n_open_cnt = w_acc.count;
                    end else begin
                        n_open_x   = '0;
                        n_open_y   = '0;
                        n_open_z   = '0;
                        n_open_cnt = '0;
                        n_elapsed  = '0;
                        if (w_full) begin
                            // fetch the oldest window and divide the current totals
                            n_close     = w_acc;
                            n_emit_cnt  = r_tot_cnt;
                            w_ram_re    = 1'b1;
                            w_div_start = 1'b1;
                            n_state     = S_RETIRE;
                        end else begin
                            w_ram_we    = 1'b1;
                            w_ram_waddr = w_append_slot;
                            w_ram_wdata = w_acc;
                            n_tot_x     = r_tot_x + TOT_W'(w_acc.sum_x);
                            n_tot_y     = r_tot_y + TOT_W'(w_acc.sum_y);
                            n_tot_z     = r_tot_z + TOT_W'(w_acc.sum_z);
                            n_tot_cnt   = r_tot_cnt + TOTC_W'(w_acc.count);
                            n_fill      = r_fill + 1'b1;
                        end
                    end
                end
            end
            S_RETIRE: begin
                n_tot_x   = r_tot_x - TOT_W'(w_old.sum_x);
                n_tot_y   = r_tot_y - TOT_W'(w_old.sum_y);
                n_tot_z   = r_tot_z - TOT_W'(w_old.sum_z);
                n_tot_cnt = r_tot_cnt - TOTC_W'(w_old.count);
                n_state   = S_ADD;
            end
            S_ADD: begin
                w_ram_we  = 1'b1;
                n_tot_x   = r_tot_x + TOT_W'(r_close.sum_x);
                n_tot_y   = r_tot_y + TOT_W'(r_close.sum_y);
                n_tot_z   = r_tot_z + TOT_W'(r_close.sum_z);
                n_tot_cnt = r_tot_cnt + TOTC_W'(r_close.count);
                n_oldest  = w_oldest_inc;
                n_state   = S_DIV;
            end
            S_DIV: begin
                // hold the result until all three dividers are done and the output register is free
                if (w_done_x && w_done_y && w_done_z && (!r_out_valid || i_ready)) begin
                    n_avg_x     = w_quot_x;
                    n_avg_y     = w_quot_y;
                    n_avg_z     = w_quot_z;
                    n_out_cnt   = OUT_CNT_W'(r_emit_cnt);
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_window_ticks <= WINDOW_TICKS_RST;
            r_open_x       <= '0;
            r_open_y       <= '0;
            r_open_z       <= '0;
            r_open_cnt     <= '0;
            r_elapsed      <= '0;
            r_fill         <= '0;
            r_oldest       <= '0;
            r_tot_x        <= '0;
            r_tot_y        <= '0;
            r_tot_z        <= '0;
            r_tot_cnt      <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_open_x    <= n_open_x;
            r_open_y    <= n_open_y;
            r_open_z    <= n_open_z;
            r_open_cnt  <= n_open_cnt;
            r_elapsed   <= n_elapsed;
            r_fill      <= n_fill;
            r_oldest    <= n_oldest;
            r_tot_x     <= n_tot_x;
            r_tot_y     <= n_tot_y;
            r_tot_z     <= n_tot_z;
            r_tot_cnt   <= n_tot_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_window_ticks <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_close    <= n_close;
        r_emit_cnt <= n_emit_cnt;
        r_avg_x    <= n_avg_x;
        r_avg_y    <= n_avg_y;
        r_avg_z    <= n_avg_z;
        r_out_cnt  <= n_out_cnt;
    end

    wma3_ring_ram #(
        .DEPTH (RING_WINDOWS),
        .WIDTH (ENTRY_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (r_oldest),
        .o_rdata (w_ram_rdata)
    );

    wma3_div u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_tot_x),
        .i_divisor  (r_tot_cnt),
        .o_done     (w_done_x),
        .o_quot     (w_quot_x)
    );

    wma3_div u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_tot_y),
        .i_divisor  (r_tot_cnt),
        .o_done     (w_done_y),
        .o_quot     (w_quot_y)
    );

    wma3_div u_div_z (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_tot_z),
        .i_divisor  (r_tot_cnt),
        .o_done     (w_done_z),
        .o_quot     (w_quot_z)
    );

    assign o_valid         = r_out_valid;
    assign o_avg_x         = r_avg_x;
    assign o_avg_y         = r_avg_y;
    assign o_avg_z         = r_avg_z;
    assign o_total_samples = r_out_cnt;

    `WMA3_CHECK(a_fill_bound, 1'b1, r_fill <= FILL_W'(RING_WINDOWS), "ring fill beyond depth")
    `WMA3_CHECK(a_oldest_before_full, !w_full, r_oldest == '0, "oldest moved before ring full")
    `WMA3_CHECK(a_busy_only_full, r_state != S_IDLE, w_full, "retire sequence with ring not full")
    `WMA3_CHECK(a_div_lockstep, 1'b1, {w_done_y, w_done_z} == {2{w_done_x}}, "dividers apart")
    `WMA3_CHECK_NEXT(a_full_close_fetch, w_close && w_full, r_state == S_RETIRE, "no fetch")
    `WMA3_CHECK(a_emit_count, o_valid, o_total_samples != '0, "result over empty ring")

endmodule
